// ----- hw/rtl/ips_pkg.sv -----
`timescale 1ns / 1ps

package ips_pkg;

    // Slot table geometry
    localparam int NUM_SLOTS = 16;
    localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // Operation codes carried in the mode field
    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_STOP  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_READ  = 2'd3
    } mode_t;

    // One input item
    typedef struct packed {
        mode_t       mode;
        logic [3:0]  slot;
        logic [31:0] timer_now;
    } req_item_t;

    // One result item
    typedef struct packed {
        logic        slot_active;
        logic [31:0] last_elapsed;
        logic [31:0] shortest_elapsed;
        logic [31:0] longest_elapsed;
        logic [31:0] sample_count;
        logic [63:0] elapsed_sum;
    } rsp_item_t;

    // Contents of one slot as stored in the table memory
    typedef struct packed {
        logic        active_flag;
        logic [31:0] start_count;
        logic [31:0] last_interval;
        logic [31:0] min_interval;
        logic [31:0] max_interval;
        logic [31:0] interval_count;
        logic [63:0] interval_sum;
    } entry_t;

    localparam entry_t ENTRY_RESET = '{
        active_flag:    1'b0,
        start_count:    32'd0,
        last_interval:  32'd0,
        min_interval:   32'hFFFF_FFFF,
        max_interval:   32'd0,
        interval_count: 32'd0,
        interval_sum:   64'd0
    };

endpackage

// ----- hw/rtl/ips_req_if.sv -----
`timescale 1ns / 1ps

interface ips_req_if;
    logic                  valid;
    logic                  ready;
    ips_pkg::req_item_t    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/ips_rsp_if.sv -----
`timescale 1ns / 1ps

interface ips_rsp_if;
    logic                  valid;
    logic                  ready;
    ips_pkg::rsp_item_t    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/interval_profiler_slots_core.sv -----
`timescale 1ns / 1ps

// Interval profiler slot table.
// req: valid/ready channel carrying mode (start, stop, clear, read), slot index
//   and the current timer count. A transfer happens when valid and ready are high.
// rsp: valid/ready channel carrying the slot's contents after the operation,
//   exactly one response per request, in request order.
// cfg_we/cfg_wdata: write of the overhead register, taken on any clock with
//   cfg_we high; write it only while no request is outstanding.
// The slot table is a single-port synchronous memory; each request runs read,
//   elapsed subtract, overhead trim and statistics update/write-back in turn
//   before the next read is issued.
// The response sits in an output register, so a new request is taken while an
//   earlier response still waits; if the receiver stalls, the update step holds
//   until the output register frees up.
// Reset: clears the per-slot valid bits (every slot reads as empty), the
//   overhead register and the control state. No clearing pass is needed.
module interval_profiler_slots_core (
    input  logic                clk,
    input  logic                rst_n,
    ips_req_if.sink             req,
    ips_rsp_if.source           rsp,
    input  logic                cfg_we,
    input  logic [31:0]         cfg_wdata
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RAW  = 4'b0010,
        S_TRIM = 4'b0100,
        S_UPD  = 4'b1000
    } state_t;

    state_t                          state_reg, state_next;
    logic [31:0]                     overhead_reg;
    logic [ips_pkg::NUM_SLOTS-1:0]   valid_reg;

    ips_pkg::entry_t                 mem [ips_pkg::NUM_SLOTS];
    ips_pkg::entry_t                 rd_data_reg;
    logic                            rd_valid_reg;

    ips_pkg::mode_t                  mode_reg;
    logic [ips_pkg::IDX_W-1:0]       idx_reg;
    logic                            slot_ok_reg;
    logic [31:0]                     now_reg;
    ips_pkg::entry_t                 entry_reg;
    logic [31:0]                     raw_reg;
    logic [31:0]                     elapsed_reg;

    logic                            rsp_valid_reg;
    ips_pkg::rsp_item_t              rsp_data_reg;

    logic                            req_fire;
    logic                            upd_go;
    logic                            mem_we;
    logic [ips_pkg::IDX_W-1:0]       req_idx;
    logic                            req_slot_ok;
    ips_pkg::entry_t                 entry_cur;
    logic [32:0]                     trim_diff;
    logic [31:0]                     elapsed_next;
    logic [64:0]                     sum_ext;
    ips_pkg::entry_t                 entry_new;
    ips_pkg::rsp_item_t              rsp_next;

    assign req_fire    = req.valid && req.ready;
    assign req.ready   = (state_reg == S_IDLE);
    assign req_idx     = ips_pkg::IDX_W'(req.data.slot);
    assign req_slot_ok = (32'(req.data.slot) < 32'(ips_pkg::NUM_SLOTS));
    assign upd_go      = (state_reg == S_UPD) && (!rsp_valid_reg || rsp.ready);
    assign mem_we      = upd_go && slot_ok_reg;

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.data    = rsp_data_reg;

    // Sequence one request through read, subtract, trim and update
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = S_RAW;
                end
            end
            S_RAW:  state_next = S_TRIM;
            S_TRIM: state_next = S_UPD;
            S_UPD:
            begin
                if (upd_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Hold the overhead register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overhead_reg <= 32'd0;
        end
        else if (cfg_we)
        begin
            overhead_reg <= cfg_wdata;
        end
    end

    // Mark slots written since reset; unmarked slots read as empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (mem_we)
        begin
            valid_reg[idx_reg] <= 1'b1;
        end
    end

    // Slot table memory: read on request transfer, write back on update
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[idx_reg] <= entry_new;
        end
        if (req_fire)
        begin
            rd_data_reg  <= mem[req_idx];
            rd_valid_reg <= valid_reg[req_idx];
        end
    end

    // Capture the request fields
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            mode_reg    <= req.data.mode;
            idx_reg     <= req_idx;
            slot_ok_reg <= req_slot_ok;
            now_reg     <= req.data.timer_now;
        end
    end

    // Take the raw elapsed time modulo 2^32
    assign entry_cur = rd_valid_reg ? rd_data_reg : ips_pkg::ENTRY_RESET;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_RAW)
        begin
            entry_reg <= entry_cur;
            raw_reg   <= now_reg - entry_cur.start_count;
        end
    end

    // Remove the overhead only when the elapsed time exceeds it
    assign trim_diff    = {1'b0, raw_reg} - {1'b0, overhead_reg};
    assign elapsed_next = (!trim_diff[32] && (trim_diff[31:0] != 32'd0))
                          ? trim_diff[31:0] : raw_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_TRIM)
        begin
            elapsed_reg <= elapsed_next;
        end
    end

    // Apply the operation to the slot
    assign sum_ext = {1'b0, entry_reg.interval_sum} + {33'd0, elapsed_reg};

    always_comb
    begin
        entry_new = entry_reg;
        case (mode_reg)
            ips_pkg::MODE_START:
            begin
                if (!entry_reg.active_flag)
                begin
                    entry_new.active_flag = 1'b1;
                    entry_new.start_count = now_reg;
                end
            end
            ips_pkg::MODE_STOP:
            begin
                if (entry_reg.active_flag)
                begin
                    entry_new.active_flag   = 1'b0;
                    entry_new.last_interval = elapsed_reg;
                    if (elapsed_reg < entry_reg.min_interval)
                    begin
                        entry_new.min_interval = elapsed_reg;
                    end
                    if (elapsed_reg > entry_reg.max_interval)
                    begin
                        entry_new.max_interval = elapsed_reg;
                    end
                    if (entry_reg.interval_count != 32'hFFFF_FFFF)
                    begin
                        entry_new.interval_count = entry_reg.interval_count + 32'd1;
                    end
                    entry_new.interval_sum = sum_ext[64] ? 64'hFFFF_FFFF_FFFF_FFFF
                                                         : sum_ext[63:0];
                end
            end
            ips_pkg::MODE_CLEAR: entry_new = ips_pkg::ENTRY_RESET;
            default:             entry_new = entry_reg;
        endcase
    end

    // Form the response; a slot outside the table answers all zeros
    always_comb
    begin
        rsp_next = '0;
        if (slot_ok_reg)
        begin
            rsp_next.slot_active      = entry_new.active_flag;
            rsp_next.last_elapsed     = entry_new.last_interval;
            rsp_next.shortest_elapsed = entry_new.min_interval;
            rsp_next.longest_elapsed  = entry_new.max_interval;
            rsp_next.sample_count     = entry_new.interval_count;
            rsp_next.elapsed_sum      = entry_new.interval_sum;
        end
    end

    // Output register: load on update, drop on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (upd_go)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_go)
        begin
            rsp_data_reg <= rsp_next;
        end
    end

`ifndef SYNTHESIS
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_fire_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg == S_RAW))
        else $error("request transfer did not start a table read");

    a_write_only_in_update: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_UPD) && !(rsp_valid_reg && !rsp.ready))
        else $error("table write outside the update step");

    a_update_loads_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        upd_go |=> rsp_valid_reg && (state_reg == S_IDLE))
        else $error("update did not present a response");

    a_write_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> valid_reg[$past(idx_reg)])
        else $error("written slot not marked valid");
`endif

endmodule
